// ===== hw/rtl/tsmm_pkg.sv =====
package tsmm_pkg;

   // Default sensor geometry
   localparam int COLUMNS_DEF = 32;
   localparam int ROWS_DEF    = 24;

   // Field widths
   localparam int RAW_W   = 16;
   localparam int IDX_W   = 10;
   localparam int AMB_W   = 10;
   localparam int BASE_W  = 13;
   localparam int GAIN_W  = 16;
   localparam int TEMP_W  = 20;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 1;

   // Divider: |raw| * 10 fits 19 bits, |gain| fits 16 bits unsigned
   localparam int NUM_W     = 19;
   localparam int MAG_W     = 16;
   localparam int DIV_CNT_W = 5;

   // Reset values of the registers
   localparam logic [GAIN_W-1:0] GAIN_RST = 16'd1;
   localparam logic [BASE_W-1:0] BASE_RST = 13'd2500;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_UPDATE,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

// ===== hw/rtl/thermal_subpage_merge_minmax_core.sv =====
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | raw_pixel, pixel_index, subpage, ambient_raw,
//         |           |                        | last_pixel
// rsp     | out       | rsp_valid / rsp_ready  | pixel_temp, pixel_written, frame_done,
//         |           |                        | frame_min, frame_max
// csr     | in        | csr_we (no wait)       | csr_index, csr_wdata
//
// Sequencing: one transaction at a time. An ordinary pixel runs from acceptance through
// the bit-serial restoring divider (one quotient bit a cycle) to a loaded result; the next
// transaction is accepted in the cycle after the load. A pixel that closes the second
// subpage read adds a frame scan, which reads the store memory one entry a cycle.
// Reset: clears control state, then sweeps the frame store to zero, one entry a cycle;
// req_ready stays low during the sweep.
// Stalls: a result waits in the output register while the next transaction is accepted
// and processed; the core holds in ST_RESP only when the output register is still full.
module thermal_subpage_merge_minmax_core #(
   parameter int COLUMNS = tsmm_pkg::COLUMNS_DEF,
   parameter int ROWS    = tsmm_pkg::ROWS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [tsmm_pkg::RAW_W-1:0]       req_raw_pixel,
   input  logic        [tsmm_pkg::IDX_W-1:0]       req_pixel_index,
   input  logic                                    req_subpage,
   input  logic        [tsmm_pkg::AMB_W-1:0]       req_ambient_raw,
   input  logic                                    req_last_pixel,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [tsmm_pkg::TEMP_W-1:0]      rsp_pixel_temp,
   output logic                                    rsp_pixel_written,
   output logic                                    rsp_frame_done,
   output logic signed [tsmm_pkg::TEMP_W-1:0]      rsp_frame_min,
   output logic signed [tsmm_pkg::TEMP_W-1:0]      rsp_frame_max,
   // configuration port
   input  logic                                    csr_we,
   input  logic        [tsmm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [tsmm_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int STORE_SIZE = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int CNT_W      = ADDR_W + 1;
   // Row = idx / COLUMNS by reciprocal multiply; estimate is low by at most one
   localparam int RECIP_SH   = 20;
   localparam int RECIP      = (1 << RECIP_SH) / COLUMNS;
   localparam int RECIP_W    = RECIP_SH + 1;
   localparam int PROD_W     = tsmm_pkg::IDX_W + RECIP_W;
   localparam int COL_W      = $clog2(COLUMNS) + 2;
   localparam logic COL_ODD  = 1'(COLUMNS % 2);

   localparam int TW = tsmm_pkg::TEMP_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [tsmm_pkg::GAIN_W-1:0] gain_ff;
   logic [tsmm_pkg::BASE_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= tsmm_pkg::GAIN_RST;
         base_ff <= tsmm_pkg::BASE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            tsmm_pkg::CSR_GAIN: gain_ff <= csr_wdata[tsmm_pkg::GAIN_W-1:0];
            tsmm_pkg::CSR_BASE: base_ff <= csr_wdata[tsmm_pkg::BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Control
   // ------------------------------------------------------------------
   tsmm_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [tsmm_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic                seen_ff, seen_in;
   logic                scan_pend_ff;
   logic                scan_first_ff;

   // Latched transaction fields
   logic [tsmm_pkg::IDX_W-1:0] idx_ff;
   logic                       sp_ff;
   logic [tsmm_pkg::AMB_W-1:0] amb_ff;
   logic                       last_ff;
   logic                       neg_ff;
   logic                       in_range_ff;
   logic [tsmm_pkg::IDX_W-1:0] row_est_ff;
   logic                       parity_ff;
   logic [tsmm_pkg::MAG_W-1:0] mag_ff;

   // Divider
   logic [tsmm_pkg::NUM_W-1:0] div_quot_ff;
   logic [tsmm_pkg::MAG_W-1:0] div_rem_ff;

   // Result hold registers
   logic signed [TW-1:0] res_temp_ff;
   logic                 res_written_ff;
   logic                 res_done_ff;
   logic signed [TW-1:0] res_min_ff;
   logic signed [TW-1:0] res_max_ff;

   // Output register
   logic                 rsp_valid_ff;
   logic signed [TW-1:0] rsp_temp_ff;
   logic                 rsp_written_ff;
   logic                 rsp_done_ff;
   logic signed [TW-1:0] rsp_min_ff;
   logic signed [TW-1:0] rsp_max_ff;

   // Memory port
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic signed [TW-1:0] mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;
   logic signed [TW-1:0] mem_rdata_ff;
   logic signed [TW-1:0] store_mem [STORE_SIZE];

   logic req_fire;
   logic rsp_load;

   // ------------------------------------------------------------------
   // Request-side preprocessing at acceptance
   // ------------------------------------------------------------------
   logic [tsmm_pkg::RAW_W:0]   raw_abs;
   logic [tsmm_pkg::NUM_W-1:0] num_abs;
   logic [tsmm_pkg::MAG_W-1:0] gain_abs;
   logic [tsmm_pkg::MAG_W-1:0] mag_next;
   logic [PROD_W-1:0]          row_prod;

   always_comb begin
      raw_abs  = req_raw_pixel[tsmm_pkg::RAW_W-1]
               ? ((tsmm_pkg::RAW_W+1)'(0) - {1'b1, req_raw_pixel})
               : {1'b0, req_raw_pixel};
      // |raw| * 10 = |raw| * 8 + |raw| * 2
      num_abs  = tsmm_pkg::NUM_W'({raw_abs, 3'b000}) + tsmm_pkg::NUM_W'({raw_abs, 1'b0});
      gain_abs = gain_ff[tsmm_pkg::GAIN_W-1] ? (tsmm_pkg::MAG_W'(0) - gain_ff) : gain_ff;
      mag_next = (gain_abs == '0) ? tsmm_pkg::MAG_W'(1) : gain_abs;
      row_prod = PROD_W'(req_pixel_index) * PROD_W'(RECIP);
   end

   // ------------------------------------------------------------------
   // Parity of row + column, corrected from the reciprocal estimate
   // ------------------------------------------------------------------
   logic [COL_W-1:0] col_est;
   logic             col_over;
   logic             parity_next;

   always_comb begin
      col_est     = COL_W'(idx_ff) - COL_W'(row_est_ff * COL_W'(COLUMNS));
      col_over    = (col_est >= COL_W'(COLUMNS));
      parity_next = col_over ? (row_est_ff[0] ^ 1'b1 ^ col_est[0] ^ COL_ODD)
                             : (row_est_ff[0] ^ col_est[0]);
   end

   // ------------------------------------------------------------------
   // Divider step: one quotient bit a cycle
   // ------------------------------------------------------------------
   logic [tsmm_pkg::MAG_W:0] rem_shift;
   logic [tsmm_pkg::MAG_W:0] rem_sub;
   logic                     rem_ge;

   always_comb begin
      rem_shift = {div_rem_ff, div_quot_ff[tsmm_pkg::NUM_W-1]};
      rem_sub   = rem_shift - {1'b0, mag_ff};
      rem_ge    = (rem_shift >= {1'b0, mag_ff});
   end

   // ------------------------------------------------------------------
   // Temperature assembly
   // ------------------------------------------------------------------
   logic [tsmm_pkg::AMB_W+3:0] amb_x10;
   logic signed [TW-1:0]       quot_s;
   logic signed [TW-1:0]       new_temp;
   logic                       pix_match;

   always_comb begin
      amb_x10   = (tsmm_pkg::AMB_W+4)'({amb_ff, 3'b000}) + (tsmm_pkg::AMB_W+4)'({amb_ff, 1'b0});
      quot_s    = neg_ff ? (TW'(0) - TW'(div_quot_ff)) : TW'(div_quot_ff);
      new_temp  = TW'(base_ff) + TW'(amb_x10) + quot_s;
      pix_match = in_range_ff && (parity_ff == sp_ff);
   end

   // ------------------------------------------------------------------
   // State machine: next state and memory control
   // ------------------------------------------------------------------
   logic scan_issue;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      seen_in    = seen_ff;
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = ADDR_W'(idx_ff);
      mem_wdata  = new_temp;
      mem_raddr  = in_range_ff ? ADDR_W'(idx_ff) : '0;
      rsp_load   = 1'b0;
      scan_issue = 1'b0;

      unique case (state_ff)
         tsmm_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            mem_wdata = '0;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STORE_SIZE - 1)) begin
               state_in = tsmm_pkg::ST_IDLE;
               cnt_in   = '0;
            end
         end
         tsmm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = tsmm_pkg::ST_DIV;
            end
         end
         tsmm_pkg::ST_DIV: begin
            if (div_cnt_ff == tsmm_pkg::DIV_CNT_W'(tsmm_pkg::NUM_W - 1)) begin
               state_in = tsmm_pkg::ST_UPDATE;
            end
         end
         tsmm_pkg::ST_UPDATE: begin
            mem_we = pix_match;
            if (last_ff && seen_ff) begin
               seen_in  = 1'b0;
               cnt_in   = '0;
               state_in = tsmm_pkg::ST_SCAN;
            end else begin
               if (last_ff) begin
                  seen_in = 1'b1;
               end
               state_in = tsmm_pkg::ST_RESP;
            end
         end
         tsmm_pkg::ST_SCAN: begin
            if (cnt_ff < CNT_W'(STORE_SIZE)) begin
               scan_issue = 1'b1;
               mem_raddr  = cnt_ff[ADDR_W-1:0];
               cnt_in     = cnt_ff + CNT_W'(1);
            end else if (!scan_pend_ff) begin
               state_in = tsmm_pkg::ST_RESP;
            end
         end
         tsmm_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = tsmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsmm_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tsmm_pkg::ST_CLEAR;
         cnt_ff        <= '0;
         seen_ff       <= 1'b0;
         scan_pend_ff  <= 1'b0;
         scan_first_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         seen_ff       <= seen_in;
         scan_pend_ff  <= scan_issue;
         scan_first_ff <= scan_issue && (cnt_ff == '0);
      end
   end

   // ------------------------------------------------------------------
   // Frame store: one write port, one registered read port
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= store_mem[mem_raddr];
   end

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         // capture the transaction and seed the divider
         idx_ff      <= req_pixel_index;
         sp_ff       <= req_subpage;
         amb_ff      <= req_ambient_raw;
         last_ff     <= req_last_pixel;
         neg_ff      <= req_raw_pixel[tsmm_pkg::RAW_W-1];
         in_range_ff <= (32'(req_pixel_index) < 32'(STORE_SIZE));
         row_est_ff  <= tsmm_pkg::IDX_W'(row_prod >> RECIP_SH);
         mag_ff      <= mag_next;
         div_quot_ff <= num_abs;
         div_rem_ff  <= '0;
         div_cnt_ff  <= '0;
      end else if (state_ff == tsmm_pkg::ST_DIV) begin
         // shift in one quotient bit, track parity alongside
         div_quot_ff <= {div_quot_ff[tsmm_pkg::NUM_W-2:0], rem_ge};
         div_rem_ff  <= rem_ge ? rem_sub[tsmm_pkg::MAG_W-1:0] : rem_shift[tsmm_pkg::MAG_W-1:0];
         div_cnt_ff  <= div_cnt_ff + tsmm_pkg::DIV_CNT_W'(1);
         parity_ff   <= parity_next;
      end

      if (state_ff == tsmm_pkg::ST_UPDATE) begin
         // slot value after the step; default frame fields to zero
         res_temp_ff    <= in_range_ff ? (pix_match ? new_temp : mem_rdata_ff) : '0;
         res_written_ff <= pix_match;
         res_done_ff    <= last_ff && seen_ff;
         res_min_ff     <= '0;
         res_max_ff     <= '0;
      end else if (scan_pend_ff) begin
         // fold one stored entry into the running extremes
         if (scan_first_ff || (mem_rdata_ff < res_min_ff)) begin
            res_min_ff <= mem_rdata_ff;
         end
         if (scan_first_ff || (mem_rdata_ff > res_max_ff)) begin
            res_max_ff <= mem_rdata_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_temp_ff    <= res_temp_ff;
         rsp_written_ff <= res_written_ff;
         rsp_done_ff    <= res_done_ff;
         rsp_min_ff     <= res_min_ff;
         rsp_max_ff     <= res_max_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_temp    = rsp_temp_ff;
   assign rsp_pixel_written = rsp_written_ff;
   assign rsp_frame_done    = rsp_done_ff;
   assign rsp_frame_min     = rsp_min_ff;
   assign rsp_frame_max     = rsp_max_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == tsmm_pkg::ST_RESP))
      else $error("response raised outside the response state");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsmm_pkg::ST_SCAN) |-> !mem_we)
      else $error("frame store written during scan");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_frame_min <= rsp_frame_max))
      else $error("frame minimum above frame maximum");

   a_idle_extremes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |-> (rsp_frame_min == '0 && rsp_frame_max == '0))
      else $error("frame extremes nonzero without a finished frame");

endmodule

// ===== tb/tb_thermal_subpage_merge_minmax_core.sv =====
`timescale 1ns / 1ps

module tb_thermal_subpage_merge_minmax_core;

   localparam int STORE_DEPTH = tsmm_pkg::COLUMNS_DEF * tsmm_pkg::ROWS_DEF;
   // Worst quiet stretch: frame scan plus divide plus a full sink stall, with margin
   localparam int STALL_LIMIT = 4 * (STORE_DEPTH + 64);
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 40;

   // One expected response transaction
   typedef struct {
      logic signed [tsmm_pkg::TEMP_W-1:0] temp;
      logic                               written;
      logic                               done;
      logic signed [tsmm_pkg::TEMP_W-1:0] fmin;
      logic signed [tsmm_pkg::TEMP_W-1:0] fmax;
   } pixel_report_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic signed [tsmm_pkg::RAW_W-1:0]     req_raw_pixel = '0;
   logic        [tsmm_pkg::IDX_W-1:0]     req_pixel_index = '0;
   logic                                  req_subpage = 1'b0;
   logic        [tsmm_pkg::AMB_W-1:0]     req_ambient_raw = '0;
   logic                                  req_last_pixel = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b1;
   logic signed [tsmm_pkg::TEMP_W-1:0]    rsp_pixel_temp;
   logic                                  rsp_pixel_written;
   logic                                  rsp_frame_done;
   logic signed [tsmm_pkg::TEMP_W-1:0]    rsp_frame_min;
   logic signed [tsmm_pkg::TEMP_W-1:0]    rsp_frame_max;
   logic                                  csr_we = 1'b0;
   logic        [tsmm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic        [tsmm_pkg::CSR_W-1:0]     csr_wdata = '0;

   // Shadow of the block: temperature store, read counter and registers
   int                                    temp_store [STORE_DEPTH];
   logic                                  one_read_closed = 1'b0;
   logic signed [tsmm_pkg::GAIN_W-1:0]    gain_reg = tsmm_pkg::GAIN_RST;
   logic        [tsmm_pkg::BASE_W-1:0]    base_reg = tsmm_pkg::BASE_RST;

   pixel_report_type                      pending_reports [$];
   int                                    error_count = 0;
   bit                                    idling_on = 1'b1;

   always #6 clock = ~clock;

   thermal_subpage_merge_minmax_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_pixel     (req_raw_pixel),
      .req_pixel_index   (req_pixel_index),
      .req_subpage       (req_subpage),
      .req_ambient_raw   (req_ambient_raw),
      .req_last_pixel    (req_last_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_temp    (rsp_pixel_temp),
      .rsp_pixel_written (rsp_pixel_written),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_min     (rsp_frame_min),
      .rsp_frame_max     (rsp_frame_max),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Convert one pixel, merge it into the shadow store and queue the expected
   // response. Only the parity that matches the subpage bit lands in the store;
   // an index past the store writes nothing and reports zero.
   function automatic void merge_pixel(input logic signed [tsmm_pkg::RAW_W-1:0] raw,
                                       input logic [tsmm_pkg::IDX_W-1:0] idx, input logic sp,
                                       input logic [tsmm_pkg::AMB_W-1:0] amb,
                                       input logic is_last);
      pixel_report_type rep;
      int               row, col, g, mag, lo, hi, k;
      int               r, a, b, slot;
      rep = '{temp: '0, written: 1'b0, done: 1'b0, fmin: '0, fmax: '0};
      slot = int'(idx);
      if (slot < STORE_DEPTH) begin
         row = slot / tsmm_pkg::COLUMNS_DEF;
         col = slot % tsmm_pkg::COLUMNS_DEF;
         if (((row + col) & 1) == int'(sp)) begin
            g = int'(gain_reg);
            mag = (g < 0) ? -g : g;
            if (mag == 0)
               mag = 1;
            r = int'(raw);
            a = int'(amb);
            b = int'(base_reg);
            // SV integer divide truncates toward zero, as the sensor math wants
            temp_store[slot] = b + a * 10 + (r * 10) / mag;
            rep.written = 1'b1;
         end
         rep.temp = temp_store[slot][tsmm_pkg::TEMP_W-1:0];
      end
      // Every closed read counts, in range or not; the second one ends the frame
      if (is_last) begin
         if (one_read_closed) begin
            one_read_closed = 1'b0;
            lo = temp_store[0];
            hi = temp_store[0];
            for (k = 1; k < STORE_DEPTH; k++) begin
               if (temp_store[k] < lo) lo = temp_store[k];
               if (temp_store[k] > hi) hi = temp_store[k];
            end
            rep.done = 1'b1;
            rep.fmin = lo[tsmm_pkg::TEMP_W-1:0];
            rep.fmax = hi[tsmm_pkg::TEMP_W-1:0];
         end else begin
            one_read_closed = 1'b1;
         end
      end
      pending_reports.push_back(rep);
   endfunction

   // Present one pixel transaction and hold it until it is accepted. Valid is
   // only dropped when an idle burst follows, so back-to-back items keep it high.
   task automatic send_pixel(input logic signed [tsmm_pkg::RAW_W-1:0] raw,
                             input logic [tsmm_pkg::IDX_W-1:0] idx, input logic sp,
                             input logic [tsmm_pkg::AMB_W-1:0] amb, input logic is_last);
      int gap;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 18)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_raw_pixel   <= raw;
      req_pixel_index <= idx;
      req_subpage     <= sp;
      req_ambient_raw <= amb;
      req_last_pixel  <= is_last;
      do @(posedge clock); while (!req_ready);
      merge_pixel(raw, idx, sp, amb, is_last);
   endtask

   // Drop valid and wait until every queued response has come back
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [tsmm_pkg::CSR_IDX_W-1:0] index,
                                 input logic [tsmm_pkg::CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         tsmm_pkg::CSR_GAIN: gain_reg = data[tsmm_pkg::GAIN_W-1:0];
         tsmm_pkg::CSR_BASE: base_reg = data[tsmm_pkg::BASE_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [tsmm_pkg::RAW_W-1:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return tsmm_pkg::RAW_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [tsmm_pkg::AMB_W-1:0] pick_ambient();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return tsmm_pkg::AMB_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // Pick a new calibration, favoring the corners of both registers
   task automatic apply_random_setting();
      logic [tsmm_pkg::CSR_W-1:0] gain, base;
      case ($urandom_range(0, 5))
         0: gain = 16'h0001;
         1: gain = 16'h0000;
         2: gain = 16'h8000;
         3: gain = 16'h7FFF;
         4: gain = 16'hFFFF;
         default: gain = tsmm_pkg::CSR_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 4))
         0: base = 16'd0;
         1: base = 16'd5000;
         2: base = 16'd8191;
         default: base = tsmm_pkg::CSR_W'($urandom_range(0, 8191));
      endcase
      // Upper bits lie outside the base register and must be dropped
      base[tsmm_pkg::CSR_W-1:tsmm_pkg::BASE_W] =
         (tsmm_pkg::CSR_W - tsmm_pkg::BASE_W)'($urandom_range(0, 7));
      settle_block();
      write_register(tsmm_pkg::CSR_GAIN, gain);
      write_register(tsmm_pkg::CSR_BASE, base);
   endtask

   // Mostly well-formed subpage reads over a run of indices, with the odd
   // burst of loose pixels: any index, any subpage, stray last flags.
   task automatic run_traffic_phase(input int quota);
      int                         sent_here, len, start, k;
      logic                       sp;
      logic [tsmm_pkg::AMB_W-1:0] amb;
      logic [tsmm_pkg::IDX_W-1:0] idx;
      sent_here = 0;
      while (sent_here < quota) begin
         if ($urandom_range(0, 6) == 0) begin
            len = int'($urandom_range(1, 8));
            for (k = 0; k < len; k++) begin
               idx = tsmm_pkg::IDX_W'($urandom_range(0, 1023));
               send_pixel(pick_raw(), idx, 1'($urandom_range(0, 1)), pick_ambient(),
                          $urandom_range(0, 5) == 0);
            end
         end else begin
            len = int'($urandom_range(1, 40));
            start = int'($urandom_range(0, STORE_DEPTH - len));
            sp = 1'($urandom_range(0, 1));
            amb = pick_ambient();
            for (k = 0; k < len; k++) begin
               idx = tsmm_pkg::IDX_W'(start + k);
               send_pixel(pick_raw(), idx, sp, amb, k == len - 1);
            end
         end
         sent_here += len;
      end
   endtask

   // Reset calibration, both parities, a subpage switch inside one read, and
   // the first frame closing on the bottom-right pixel.
   task automatic test_reset_defaults();
      send_pixel(16'sh7FFF, 10'd0, 1'b0, 10'd1023, 1'b0);
      send_pixel(16'sh8000, 10'd1, 1'b0, 10'd0, 1'b0);
      send_pixel(16'shFFFF, 10'd1, 1'b1, 10'd1023, 1'b1);
      send_pixel(16'sh0000, 10'd767, 1'b0, 10'd0, 1'b1);
   endtask

   // Corner gains (most negative, zero, most positive, minus one) against
   // corner bases and full-scale raw words of both signs.
   task automatic test_register_extremes();
      logic [tsmm_pkg::CSR_W-1:0] gains [4];
      logic [tsmm_pkg::CSR_W-1:0] bases [4];
      int                         k;
      gains = '{16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF};
      bases = '{16'd8191, 16'd0, 16'd5000, 16'd0};
      for (k = 0; k < 4; k++) begin
         settle_block();
         write_register(tsmm_pkg::CSR_GAIN, gains[k]);
         write_register(tsmm_pkg::CSR_BASE, bases[k]);
         send_pixel(16'sh7FFF, 10'd33, 1'b0, 10'd1023, 1'b0);
         send_pixel(16'sh8000, 10'd34, 1'b1, 10'd0, 1'b1);
      end
   endtask

   // Indices past the store write nothing but still close reads
   task automatic test_outside_store();
      send_pixel(16'sh1234, 10'd768, 1'b0, 10'd512, 1'b1);
      send_pixel(16'shFEDC, 10'd1023, 1'b1, 10'd1023, 1'b1);
      send_pixel(16'sh7FFF, 10'd800, 1'b1, 10'd0, 1'b0);
   endtask

   task automatic test_mixed_reads();
      int p;
      for (p = 0; p < 7; p++) begin
         apply_random_setting();
         run_traffic_phase(115);
      end
   endtask

   // Close with both sides streaming flat out
   task automatic test_streaming_tail();
      settle_block();
      idling_on = 1'b0;
      apply_random_setting();
      run_traffic_phase(120);
   endtask

   // Random backpressure bursts on the response side
   initial begin : rsp_backpressure
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold == 0 && idling_on && $urandom_range(0, 9) == 0)
            hold = int'($urandom_range(1, 18));
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare every accepted response transaction with the oldest expectation
   always @(posedge clock) begin
      pixel_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected transaction: pixel_temp %0d", rsp_pixel_temp);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_pixel_temp !== want.temp) begin
               $error("pixel_temp: expected %0d, got %0d", want.temp, rsp_pixel_temp);
               error_count++;
            end
            if (rsp_pixel_written !== want.written) begin
               $error("pixel_written: expected %0d, got %0d", want.written, rsp_pixel_written);
               error_count++;
            end
            if (rsp_frame_done !== want.done) begin
               $error("frame_done: expected %0d, got %0d", want.done, rsp_frame_done);
               error_count++;
            end
            if (rsp_frame_min !== want.fmin) begin
               $error("frame_min: expected %0d, got %0d", want.fmin, rsp_frame_min);
               error_count++;
            end
            if (rsp_frame_max !== want.fmax) begin
               $error("frame_max: expected %0d, got %0d", want.fmax, rsp_frame_max);
               error_count++;
            end
         end
      end
   end

   // Abort when no transaction moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_thermal_subpage_merge_minmax_core: errors");
      $finish;
   end

   initial begin : main_sequence
      int k;
      for (k = 0; k < STORE_DEPTH; k++)
         temp_store[k] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_outside_store();
      test_mixed_reads();
      test_streaming_tail();

      // Drain, then give stragglers time to show up
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_thermal_subpage_merge_minmax_core: clean");
      else
         $display("tb_thermal_subpage_merge_minmax_core: errors");
      $finish;
   end

endmodule
